// File: design/cp2bm_pkg.sv
// ----------------------------------------------------------------------------
// Cell parameters to basis matrix: shared definitions
// Widths, fixed-point constants, the CORDIC arctangent table, saturation and
// the records that travel beside the square-root and divider pipelines.
// ----------------------------------------------------------------------------
package cp2bm_pkg;

  localparam int FRAC_BITS_DEF     = 12;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int LEN_W       = 16;   // edge length and angle codes
  localparam int LEN_FRAC    = 12;
  localparam int OUT_W       = 19;   // one matrix entry
  localparam int X_W         = 33;   // CORDIC x and y, Q30
  localparam int Z_W         = 27;   // CORDIC angle, 2^-16 degree
  localparam int COS_W       = 32;   // cosine and sine, Q30
  localparam int P_W         = 64;   // trig products, Q60
  localparam int SQ_W        = 34;   // rounded squares, Q30
  localparam int T_W         = 33;   // cos alpha - cos beta cos gamma
  localparam int RAD_W       = 35;   // radicand, Q30
  localparam int LP_W        = 49;   // length times trig, Q42
  localparam int CT_W        = 50;   // c times t
  localparam int CV_W        = 48;   // c times square root
  localparam int SQRT_W      = 64;   // square-root operand
  localparam int ROOT_W      = 32;
  localparam int SQRT_STEPS  = 32;
  localparam int TDATA_IN_W  = 96;
  localparam int TDATA_OUT_W = 120;

  localparam logic signed [X_W-1:0] CORDIC_GAIN = 33'sd652032874;
  localparam logic signed [Z_W-1:0] DEG90       = 27'sd5898240;
  localparam logic signed [Z_W-1:0] DEG180      = 27'sd11796480;
  localparam logic [LEN_W-1:0]      GAMMA_180   = 16'd46080;

  localparam logic signed [P_W-1:0]   HALF30 = 64'sd536870912;
  localparam logic signed [RAD_W-1:0] ONE30  = 35'sd1073741824;

  localparam logic signed [63:0] OUT_MAX_L = 64'sd262143;
  localparam logic signed [63:0] OUT_MIN_L = -64'sd262144;

  typedef logic signed [OUT_W-1:0] entry_t;

  // Travels beside the square-root pipeline.
  typedef struct packed {
    entry_t                   xx;
    entry_t                   xy;
    entry_t                   xz;
    entry_t                   yy;
    logic                     bad;
    logic [LEN_W-1:0]         c;
    logic signed [CT_W-1:0]   ct;
    logic signed [COS_W-1:0]  sg;
  } sq_side_t;

  // Travels beside the two dividers.
  typedef struct packed {
    entry_t xx;
    entry_t xy;
    entry_t xz;
    entry_t yy;
    logic   bad;
    logic   neg_yz;
    logic   neg_zz;
    logic   ovf_yz;
    logic   ovf_zz;
  } dv_side_t;

  // Arctangent of 2^-i in units of 2^-16 degree.
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [Z_W-1:0] r;
    case (i)
      5'd0:  r = 27'sd2949120;
      5'd1:  r = 27'sd1740967;
      5'd2:  r = 27'sd919879;
      5'd3:  r = 27'sd466945;
      5'd4:  r = 27'sd234379;
      5'd5:  r = 27'sd117304;
      5'd6:  r = 27'sd58666;
      5'd7:  r = 27'sd29335;
      5'd8:  r = 27'sd14668;
      5'd9:  r = 27'sd7334;
      5'd10: r = 27'sd3667;
      5'd11: r = 27'sd1833;
      5'd12: r = 27'sd917;
      5'd13: r = 27'sd458;
      5'd14: r = 27'sd229;
      5'd15: r = 27'sd115;
      5'd16: r = 27'sd57;
      5'd17: r = 27'sd29;
      5'd18: r = 27'sd14;
      5'd19: r = 27'sd7;
      5'd20: r = 27'sd4;
      5'd21: r = 27'sd2;
      5'd22: r = 27'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic entry_t sat_entry(input logic signed [63:0] v);
    entry_t r;
    if (v > OUT_MAX_L) begin
      r = OUT_W'(OUT_MAX_L);
    end else if (v < OUT_MIN_L) begin
      r = OUT_W'(OUT_MIN_L);
    end else begin
      r = OUT_W'(v);
    end
    return r;
  endfunction

endpackage

// File: design/cell_params_to_basis_matrix.sv
// ----------------------------------------------------------------------------
// Cell parameters to basis matrix
// Turns three cell edge lengths and three angles into the six nonzero entries
// of the upper-triangular fractional-to-Cartesian basis matrix.
// ----------------------------------------------------------------------------
// One request per clock cycle is taken and one result leaves per cycle
// while the output is not stalled. The pipeline is made of the rotation CORDIC
// (an input register and one stage per iteration), five arithmetic stages,
// a 32-stage square root that resolves one root bit per stage, two stages of
// numerator and denominator setup and a 19-stage restoring divider, one
// quotient bit per stage, followed by the output register. The whole
// pipeline holds while a result waits at the output.
// result_valid (tuser) is low, with all entries zero, when gamma is 0 or 180
// degrees, the computed sine of gamma is zero, or the volume radicand is
// negative. All entries saturate.
module cell_params_to_basis_matrix
  import cp2bm_pkg::*;
#(
  parameter int FRAC_BITS     = FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // length_a, length_b, length_c, angle_alpha, angle_beta, angle_gamma
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // entry_xx, entry_xy, entry_xz, entry_yy, entry_yz, entry_zz, zero pad
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  // result_valid
  output logic                   m_axis_tuser
);

  localparam int N          = CORDIC_STAGES;
  localparam int NUM_UP     = (FRAC_BITS > LEN_FRAC) ? (FRAC_BITS - LEN_FRAC) : 0;
  localparam int DEN_UP     = (FRAC_BITS < LEN_FRAC) ? (LEN_FRAC - FRAC_BITS) : 0;
  localparam int PROD_SHIFT = 42 - FRAC_BITS;
  localparam int DIV_W      = 56 + NUM_UP;
  localparam int QB         = OUT_W;
  localparam int VLD_N      = N + 6 + SQRT_STEPS + 2 + QB;
  localparam logic signed [63:0] LEN_HALF = 64'sd1 <<< (PROD_SHIFT - 1);

  function automatic logic signed [63:0] round_len(input logic signed [LP_W-1:0] p);
    return (64'(p) + LEN_HALF) >>> PROD_SHIFT;
  endfunction

  function automatic entry_t finish_div(input logic [QB-1:0] q, input logic ovf,
                                        input logic neg);
    entry_t r;
    if (neg) begin
      if (ovf || q > QB'(262144)) begin
        r = OUT_W'(OUT_MIN_L);
      end else begin
        r = OUT_W'(-$signed({1'b0, q}));
      end
    end else begin
      if (ovf || q > QB'(262143)) begin
        r = OUT_W'(OUT_MAX_L);
      end else begin
        r = OUT_W'(q);
      end
    end
    return r;
  endfunction

  // Flow control: the pipeline moves as one whenever the output can take a result.
  logic                   adv;
  logic [VLD_N-1:0]       vld_q, vld_d;
  logic                   m_tvalid_q;
  logic [TDATA_OUT_W-1:0] m_tdata_q, m_tdata_d;
  logic                   m_tuser_q;

  assign adv           = !m_tvalid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign vld_d         = {vld_q[VLD_N-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      m_tvalid_q <= 1'b0;
    end else if (adv) begin
      vld_q      <= vld_d;
      m_tvalid_q <= vld_q[VLD_N-1];
    end
  end

  // --------------------------------------------------------------------------
  // CORDIC, three angles side by side
  // --------------------------------------------------------------------------
  logic signed [X_W-1:0] cx_q [3][N+1];
  logic signed [X_W-1:0] cy_q [3][N+1];
  logic signed [Z_W-1:0] cz_q [3][N+1];
  logic                  cneg_q [3][N+1];
  logic [LEN_W-1:0]      la_q [N+1];
  logic [LEN_W-1:0]      lb_q [N+1];
  logic [LEN_W-1:0]      lc_q [N+1];
  logic                  gbad_q [N+1];
  logic [LEN_W-1:0]      gamma_code;

  assign gamma_code = s_axis_tdata[5*LEN_W +: LEN_W];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      la_q[0]   <= s_axis_tdata[0 +: LEN_W];
      lb_q[0]   <= s_axis_tdata[LEN_W +: LEN_W];
      lc_q[0]   <= s_axis_tdata[2*LEN_W +: LEN_W];
      gbad_q[0] <= (gamma_code == '0) || (gamma_code == GAMMA_180);
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_ang
    logic signed [Z_W-1:0] zin, zf;
    logic                  nf;

    // Angles past 90 degrees are folded back and the cosine is negated.
    always_comb begin
      zin = Z_W'({s_axis_tdata[(3+g)*LEN_W +: LEN_W], 8'd0});
      if (zin > DEG90) begin
        zf = DEG180 - zin;
        nf = 1'b1;
      end else begin
        zf = zin;
        nf = 1'b0;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        cx_q[g][0]   <= CORDIC_GAIN;
        cy_q[g][0]   <= '0;
        cz_q[g][0]   <= zf;
        cneg_q[g][0] <= nf;
      end
    end

    for (genvar k = 0; k < N; k++) begin : g_it
      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (!cz_q[g][k][Z_W-1]) begin
            cx_q[g][k+1] <= cx_q[g][k] - (cy_q[g][k] >>> k);
            cy_q[g][k+1] <= cy_q[g][k] + (cx_q[g][k] >>> k);
            cz_q[g][k+1] <= cz_q[g][k] - atan_lut(5'(k));
          end else begin
            cx_q[g][k+1] <= cx_q[g][k] + (cy_q[g][k] >>> k);
            cy_q[g][k+1] <= cy_q[g][k] - (cx_q[g][k] >>> k);
            cz_q[g][k+1] <= cz_q[g][k] + atan_lut(5'(k));
          end
          cneg_q[g][k+1] <= cneg_q[g][k];
        end
      end
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_cside
    always_ff @(posedge clk_i) begin
      if (adv) begin
        la_q[k+1]   <= la_q[k];
        lb_q[k+1]   <= lb_q[k];
        lc_q[k+1]   <= lc_q[k];
        gbad_q[k+1] <= gbad_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Products and the radicand
  // --------------------------------------------------------------------------
  logic signed [COS_W-1:0] m1_cos_q [3];
  logic signed [COS_W-1:0] m1_sg_q;
  logic [LEN_W-1:0]        m1_a_q, m1_b_q, m1_c_q;
  logic                    m1_bad_q;

  logic signed [P_W-1:0]   m2_sq_q [3];
  logic signed [P_W-1:0]   m2_cbcg_q;
  logic signed [LP_W-1:0]  m2_pbcg_q, m2_pccb_q, m2_pbsg_q;
  entry_t                  m2_xx_q;
  logic signed [COS_W-1:0] m2_ca_q, m2_sg_q;
  logic [LEN_W-1:0]        m2_c_q;
  logic                    m2_bad_q;

  logic signed [SQ_W-1:0]  m3_sq_q [3];
  logic signed [COS_W-1:0] m3_cbcg_q, m3_ca_q, m3_sg_q;
  entry_t                  m3_xx_q, m3_xy_q, m3_xz_q, m3_yy_q;
  logic [LEN_W-1:0]        m3_c_q;
  logic                    m3_bad_q;

  logic signed [P_W-1:0]   m4_trip_q;
  logic signed [T_W-1:0]   m4_t_q;
  logic signed [RAD_W-1:0] m4_s_q;
  entry_t                  m4_xx_q, m4_xy_q, m4_xz_q, m4_yy_q;
  logic signed [COS_W-1:0] m4_sg_q;
  logic [LEN_W-1:0]        m4_c_q;
  logic                    m4_bad_q;

  logic signed [RAD_W-1:0] m5_trip, m5_rad;
  logic [SQRT_W-1:0]       m5_rad_q;
  sq_side_t                m5_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int g = 0; g < 3; g++) begin
        m1_cos_q[g] <= COS_W'(cneg_q[g][N] ? -cx_q[g][N] : cx_q[g][N]);
      end
      m1_sg_q  <= COS_W'(cy_q[2][N]);
      m1_a_q   <= la_q[N];
      m1_b_q   <= lb_q[N];
      m1_c_q   <= lc_q[N];
      m1_bad_q <= gbad_q[N] || (cy_q[2][N] == '0);

      for (int g = 0; g < 3; g++) begin
        m2_sq_q[g] <= P_W'(m1_cos_q[g]) * P_W'(m1_cos_q[g]);
      end
      m2_cbcg_q <= P_W'(m1_cos_q[1]) * P_W'(m1_cos_q[2]);
      m2_pbcg_q <= LP_W'($signed({1'b0, m1_b_q})) * LP_W'(m1_cos_q[2]);
      m2_pccb_q <= LP_W'($signed({1'b0, m1_c_q})) * LP_W'(m1_cos_q[1]);
      m2_pbsg_q <= LP_W'($signed({1'b0, m1_b_q})) * LP_W'(m1_sg_q);
      m2_xx_q   <= sat_entry($signed((64'(m1_a_q) << FRAC_BITS) + 64'd2048) >>> LEN_FRAC);
      m2_ca_q   <= m1_cos_q[0];
      m2_sg_q   <= m1_sg_q;
      m2_c_q    <= m1_c_q;
      m2_bad_q  <= m1_bad_q;

      for (int g = 0; g < 3; g++) begin
        m3_sq_q[g] <= SQ_W'((m2_sq_q[g] + HALF30) >>> 30);
      end
      m3_cbcg_q <= COS_W'((m2_cbcg_q + HALF30) >>> 30);
      m3_xy_q   <= sat_entry(round_len(m2_pbcg_q));
      m3_xz_q   <= sat_entry(round_len(m2_pccb_q));
      m3_yy_q   <= sat_entry(round_len(m2_pbsg_q));
      m3_xx_q   <= m2_xx_q;
      m3_ca_q   <= m2_ca_q;
      m3_sg_q   <= m2_sg_q;
      m3_c_q    <= m2_c_q;
      m3_bad_q  <= m2_bad_q;

      m4_trip_q <= P_W'(m3_ca_q) * P_W'(m3_cbcg_q);
      m4_t_q    <= T_W'(m3_ca_q) - T_W'(m3_cbcg_q);
      m4_s_q    <= ONE30 - RAD_W'(m3_sq_q[0]) - RAD_W'(m3_sq_q[1]) - RAD_W'(m3_sq_q[2]);
      m4_xx_q   <= m3_xx_q;
      m4_xy_q   <= m3_xy_q;
      m4_xz_q   <= m3_xz_q;
      m4_yy_q   <= m3_yy_q;
      m4_sg_q   <= m3_sg_q;
      m4_c_q    <= m3_c_q;
      m4_bad_q  <= m3_bad_q;
    end
  end

  assign m5_trip = RAD_W'((m4_trip_q + HALF30) >>> 30);
  assign m5_rad  = m4_s_q + (m5_trip <<< 1);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m5_rad_q     <= m5_rad[RAD_W-1] ? '0 : (SQRT_W'(m5_rad) << 30);
      m5_side_q.xx <= m4_xx_q;
      m5_side_q.xy <= m4_xy_q;
      m5_side_q.xz <= m4_xz_q;
      m5_side_q.yy <= m4_yy_q;
      m5_side_q.bad <= m4_bad_q || m5_rad[RAD_W-1];
      m5_side_q.c  <= m4_c_q;
      m5_side_q.ct <= CT_W'($signed({1'b0, m4_c_q})) * CT_W'(m4_t_q);
      m5_side_q.sg <= m4_sg_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square root, one result bit per stage
  // --------------------------------------------------------------------------
  logic [SQRT_W-1:0] sr_rem_q [SQRT_STEPS];
  logic [SQRT_W-1:0] sr_res_q [SQRT_STEPS];
  sq_side_t          sr_side_q [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (SQRT_W - 2 - 2*j);
    logic [SQRT_W-1:0] rem_in, res_in, trial;
    sq_side_t          side_in;

    if (j == 0) begin : g_first
      assign rem_in  = m5_rad_q;
      assign res_in  = '0;
      assign side_in = m5_side_q;
    end else begin : g_rest
      assign rem_in  = sr_rem_q[j-1];
      assign res_in  = sr_res_q[j-1];
      assign side_in = sr_side_q[j-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rem_in >= trial) begin
          sr_rem_q[j] <= rem_in - trial;
          sr_res_q[j] <= (res_in >> 1) + BIT;
        end else begin
          sr_rem_q[j] <= rem_in;
          sr_res_q[j] <= res_in >> 1;
        end
        sr_side_q[j] <= side_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider setup
  // --------------------------------------------------------------------------
  logic [CV_W-1:0]       mv_cv_q;
  sq_side_t              mv_side_q;
  logic signed [CT_W-1:0]  abs_ct;
  logic signed [COS_W-1:0] abs_sg;
  logic [DIV_W-1:0]      un_yz, un_zz, ud, n2_yz, n2_zz, d2;
  dv_side_t              dp_side;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mv_cv_q   <= CV_W'(sr_side_q[SQRT_STEPS-1].c)
                   * CV_W'(sr_res_q[SQRT_STEPS-1][ROOT_W-1:0]);
      mv_side_q <= sr_side_q[SQRT_STEPS-1];
    end
  end

  always_comb begin
    abs_ct = mv_side_q.ct[CT_W-1] ? -mv_side_q.ct : mv_side_q.ct;
    abs_sg = mv_side_q.sg[COS_W-1] ? -mv_side_q.sg : mv_side_q.sg;
    un_yz  = DIV_W'($unsigned(abs_ct)) << NUM_UP;
    un_zz  = DIV_W'(mv_cv_q) << NUM_UP;
    ud     = DIV_W'($unsigned(abs_sg)) << DEN_UP;
    // Rounding to nearest: floor((2n + d) / 2d).
    n2_yz  = (un_yz << 1) + ud;
    n2_zz  = (un_zz << 1) + ud;
    d2     = ud << 1;
    dp_side.xx     = mv_side_q.xx;
    dp_side.xy     = mv_side_q.xy;
    dp_side.xz     = mv_side_q.xz;
    dp_side.yy     = mv_side_q.yy;
    dp_side.bad    = mv_side_q.bad;
    dp_side.neg_yz = mv_side_q.ct[CT_W-1] != mv_side_q.sg[COS_W-1];
    dp_side.neg_zz = mv_side_q.sg[COS_W-1];
    // Any quotient that needs more than QB bits saturates anyway.
    dp_side.ovf_yz = (n2_yz >> QB) >= d2;
    dp_side.ovf_zz = (n2_zz >> QB) >= d2;
  end

  logic [DIV_W-1:0] dp_n_q [2];
  logic [DIV_W-1:0] dp_d_q;
  dv_side_t         dp_side_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dp_n_q[0] <= n2_yz;
      dp_n_q[1] <= n2_zz;
      dp_d_q    <= d2;
      dp_side_q <= dp_side;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring dividers, one quotient bit per stage, most significant first
  // --------------------------------------------------------------------------
  logic [DIV_W-1:0] dr_q [2][QB];
  logic [QB-1:0]    dq_q [2][QB];
  logic [DIV_W-1:0] dd_q [QB];
  dv_side_t         ds_q [QB];

  for (genvar m = 0; m < QB; m++) begin : g_div
    localparam int K = QB - 1 - m;
    logic [DIV_W-1:0] d_in;
    dv_side_t         s_in;

    if (m == 0) begin : g_first
      assign d_in = dp_d_q;
      assign s_in = dp_side_q;
    end else begin : g_rest
      assign d_in = dd_q[m-1];
      assign s_in = ds_q[m-1];
    end

    for (genvar u = 0; u < 2; u++) begin : g_unit
      logic [DIV_W-1:0] r_in, sub;
      logic [QB-1:0]    q_in;

      if (m == 0) begin : g_first
        assign r_in = dp_n_q[u];
        assign q_in = '0;
      end else begin : g_rest
        assign r_in = dr_q[u][m-1];
        assign q_in = dq_q[u][m-1];
      end

      assign sub = d_in << K;

      always_ff @(posedge clk_i) begin
        if (adv) begin
          if (r_in >= sub) begin
            dr_q[u][m] <= r_in - sub;
            dq_q[u][m] <= q_in | (QB'(1) << K);
          end else begin
            dr_q[u][m] <= r_in;
            dq_q[u][m] <= q_in;
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dd_q[m] <= d_in;
        ds_q[m] <= s_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  entry_t   yz, zz;
  dv_side_t fin;

  assign fin = ds_q[QB-1];
  assign yz  = finish_div(dq_q[0][QB-1], fin.ovf_yz, fin.neg_yz);
  assign zz  = finish_div(dq_q[1][QB-1], fin.ovf_zz, fin.neg_zz);

  always_comb begin
    if (fin.bad) begin
      m_tdata_d = '0;
    end else begin
      m_tdata_d = TDATA_OUT_W'({zz, yz, fin.yy, fin.xz, fin.xy, fin.xx});
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_tdata_q <= m_tdata_d;
      m_tuser_q <= !fin.bad;
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid result carries nonzero entries");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(vld_q))
    else $error("pipeline moved while the output was stalled");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> vld_q[0])
    else $error("accepted request did not enter the pipeline");

  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[VLD_N-1]))
    else $error("result appeared without a request in the last stage");

endmodule
